// ===== src/sepl_pkg.sv =====
// shared types and constants for the shared edge pair lookup
`default_nettype none

package sepl_pkg;

  localparam int OP_W        = 2;
  localparam int FIELD_ID_W  = 16;
  localparam int INDEX_OUT_W = 10;

  typedef enum logic [OP_W-1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_QUERY  = 2'd2
  } op_t;

  // control travelling with each transaction along the cell chain
  typedef struct packed {
    logic            valid;
    logic [OP_W-1:0] op;
    logic            hit;
  } stage_ctl_t;

endpackage

`default_nettype wire

// ===== src/sepl_in_if.sv =====
// input channel: opcode and node id pair
`default_nettype none

interface sepl_in_if;
  import sepl_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [OP_W-1:0]       opcode;
  logic [FIELD_ID_W-1:0] node_a;
  logic [FIELD_ID_W-1:0] node_b;

  modport source (output valid, opcode, node_a, node_b, input ready);
  modport sink   (input valid, opcode, node_a, node_b, output ready);
endinterface

`default_nettype wire

// ===== src/sepl_out_if.sv =====
// result channel: match, index and status flags
`default_nettype none

interface sepl_out_if;
  import sepl_pkg::*;

  logic                   valid;
  logic                   ready;
  logic                   found;
  logic [INDEX_OUT_W-1:0] pair_index;
  logic                   table_overflow;
  logic                   surface_open;

  modport source (output valid, found, pair_index, table_overflow, surface_open, input ready);
  modport sink   (input valid, found, pair_index, table_overflow, surface_open, output ready);
endinterface

`default_nettype wire

// ===== src/sepl_cell.sv =====
// one table slot of the chain: holds an edge entry and acts on passing transactions
`default_nettype none

module sepl_cell #(
  parameter int ID_W     = 16,
  parameter int IDX_W    = 10,
  parameter int CELL_IDX = 0
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                adv,
  input  sepl_pkg::stage_ctl_t ctl_in,
  input  logic [ID_W-1:0]     a_in,
  input  logic [ID_W-1:0]     b_in,
  input  logic [IDX_W-1:0]    idx_in,
  output sepl_pkg::stage_ctl_t ctl_out,
  output logic [ID_W-1:0]     a_out,
  output logic [ID_W-1:0]     b_out,
  output logic [IDX_W-1:0]    idx_out
);
  import sepl_pkg::*;

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

  logic             occupied;
  logic             occupied_next;
  logic [ID_W-1:0]  first;
  logic [ID_W-1:0]  second;
  logic             store;
  logic             match;
  stage_ctl_t       ctl_next;
  logic [IDX_W-1:0] idx_next;

  // unordered pair compare
  assign match = occupied &&
                 (((first == a_in) && (second == b_in)) ||
                  ((first == b_in) && (second == a_in)));

  always_comb begin
    ctl_next      = ctl_in;
    idx_next      = idx_in;
    occupied_next = occupied;
    store         = 1'b0;
    if (ctl_in.valid) begin
      case (ctl_in.op)
        OP_CLEAR: begin
          occupied_next = 1'b0;
        end
        OP_APPEND: begin
          // first free slot along the chain takes the entry
          if (!ctl_in.hit && !occupied) begin
            store         = 1'b1;
            occupied_next = 1'b1;
            ctl_next.hit  = 1'b1;
            idx_next      = MY_IDX;
          end
        end
        OP_QUERY: begin
          // earlier cells win, so the lowest index sticks
          if (!ctl_in.hit && match) begin
            ctl_next.hit = 1'b1;
            idx_next     = MY_IDX;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occupied <= 1'b0;
      ctl_out  <= '0;
    end else if (adv) begin
      occupied <= occupied_next;
      ctl_out  <= ctl_next;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_out   <= a_in;
      b_out   <= b_in;
      idx_out <= idx_next;
      if (store) begin
        first  <= a_in;
        second <= b_in;
      end
    end
  end

endmodule

`default_nettype wire

// ===== src/sepl_tail.sv =====
// end of the chain: result register, sticky open-surface flag and stall control
`default_nettype none

module sepl_tail #(
  parameter int IDX_W = 10
) (
  input  logic                 clk,
  input  logic                 rst,
  input  sepl_pkg::stage_ctl_t tail_ctl,
  input  logic [IDX_W-1:0]     tail_idx,
  output logic                 adv,
  sepl_out_if.source           result_out
);
  import sepl_pkg::*;

  logic                           out_valid;
  logic                           open_flag;
  logic                           open_next;
  logic                           found_next;
  logic                           ovf_next;
  logic [INDEX_OUT_W-1:0]         index_next;
  logic [IDX_W+INDEX_OUT_W-1:0]   idx_wide;
  logic                           res_found;
  logic [INDEX_OUT_W-1:0]         res_index;
  logic                           res_overflow;
  logic                           res_open;

  // whole chain moves only when the result register can take a transaction
  assign adv = !out_valid || result_out.ready;

  assign idx_wide = {{INDEX_OUT_W{1'b0}}, tail_idx};

  always_comb begin
    open_next  = open_flag;
    found_next = 1'b0;
    ovf_next   = 1'b0;
    index_next = '0;
    case (tail_ctl.op)
      OP_CLEAR: begin
        open_next = 1'b0;
      end
      OP_APPEND: begin
        if (tail_ctl.hit) begin
          index_next = idx_wide[INDEX_OUT_W-1:0];
        end else begin
          ovf_next = 1'b1;
        end
      end
      OP_QUERY: begin
        if (tail_ctl.hit) begin
          found_next = 1'b1;
          index_next = idx_wide[INDEX_OUT_W-1:0];
        end else begin
          open_next = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      open_flag <= 1'b0;
    end else if (adv) begin
      out_valid <= tail_ctl.valid;
      if (tail_ctl.valid) begin
        open_flag <= open_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && tail_ctl.valid) begin
      res_found    <= found_next;
      res_index    <= index_next;
      res_overflow <= ovf_next;
      res_open     <= open_next;
    end
  end

  assign result_out.valid          = out_valid;
  assign result_out.found          = res_found;
  assign result_out.pair_index     = res_index;
  assign result_out.table_overflow = res_overflow;
  assign result_out.surface_open   = res_open;

endmodule

`default_nettype wire

// ===== src/shared_edge_pair_lookup.sv =====
// top level: shared edge pair lookup built as a chain of table cells
//
//   channel     dir  fields
//   item_in     in   opcode, node_a, node_b
//   result_out  out  found, pair_index, table_overflow, surface_open
//
// one transaction enters per cycle while the chain is not stalled; each passes every cell in turn,
// one cell a cycle, and its result is then registered in the tail after the last cell.
// cell k holds table slot k; appends fill the first free cell, queries keep the first hit.
// reset empties every cell and clears the open-surface flag; no clearing pass is needed.
// a stalled result freezes the whole chain and drops item_in.ready in the same cycle.
`default_nettype none

module shared_edge_pair_lookup #(
  parameter int MAX_PAIRS    = 1024,
  parameter int NODE_ID_BITS = 16
) (
  input  logic       clk,
  input  logic       rst,
  sepl_in_if.sink    item_in,
  sepl_out_if.source result_out
);
  import sepl_pkg::*;

  localparam int IDX_W = (MAX_PAIRS > 1) ? $clog2(MAX_PAIRS) : 1;

  stage_ctl_t              chain_ctl [MAX_PAIRS+1];
  logic [NODE_ID_BITS-1:0] chain_a   [MAX_PAIRS+1];
  logic [NODE_ID_BITS-1:0] chain_b   [MAX_PAIRS+1];
  logic [IDX_W-1:0]        chain_idx [MAX_PAIRS+1];
  logic                    adv;

  assign item_in.ready = adv;

  always_comb begin
    chain_ctl[0].valid = item_in.valid;
    chain_ctl[0].op    = item_in.opcode;
    chain_ctl[0].hit   = 1'b0;
  end

  assign chain_a[0]   = NODE_ID_BITS'(item_in.node_a);
  assign chain_b[0]   = NODE_ID_BITS'(item_in.node_b);
  assign chain_idx[0] = '0;

  for (genvar k = 0; k < MAX_PAIRS; k++) begin : g_cell
    sepl_cell #(
      .ID_W     (NODE_ID_BITS),
      .IDX_W    (IDX_W),
      .CELL_IDX (k)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .adv     (adv),
      .ctl_in  (chain_ctl[k]),
      .a_in    (chain_a[k]),
      .b_in    (chain_b[k]),
      .idx_in  (chain_idx[k]),
      .ctl_out (chain_ctl[k+1]),
      .a_out   (chain_a[k+1]),
      .b_out   (chain_b[k+1]),
      .idx_out (chain_idx[k+1])
    );
  end

  sepl_tail #(
    .IDX_W (IDX_W)
  ) u_tail (
    .clk        (clk),
    .rst        (rst),
    .tail_ctl   (chain_ctl[MAX_PAIRS]),
    .tail_idx   (chain_idx[MAX_PAIRS]),
    .adv        (adv),
    .result_out (result_out)
  );

  a_valid_after_reset: assert property (@(posedge clk) rst |=> !result_out.valid)
    else $error("result valid right after reset");

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (result_out.valid && !result_out.ready) |-> !item_in.ready)
    else $error("input taken while result stalled");

  a_overflow_clean: assert property (@(posedge clk) disable iff (rst)
    (result_out.valid && result_out.table_overflow) |->
      (!result_out.found && (result_out.pair_index == '0)))
    else $error("overflow result carries a match or index");

  a_clear_never_hits: assert property (@(posedge clk) disable iff (rst)
    (chain_ctl[MAX_PAIRS].valid && (chain_ctl[MAX_PAIRS].op == OP_CLEAR)) |->
      !chain_ctl[MAX_PAIRS].hit)
    else $error("clear transaction marked as hit");

endmodule

`default_nettype wire
